>>> design/trs_pkg.sv
// Package of types and constants shared by the radio sequencer modules.
package trs_pkg;

   localparam int MAX_ENTRIES_DEF = 16;
   localparam int ID_W = 4;

   localparam logic [1:0] OP_LOAD     = 2'd0;
   localparam logic [1:0] OP_ACTIVATE = 2'd1;
   localparam logic [1:0] OP_TICK     = 2'd2;
   localparam logic [1:0] OP_DISABLED = 2'd3;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_FULL    = 2'd1;
   localparam logic [1:0] ST_BAD_ID  = 2'd2;

   localparam logic [2:0] CAUSE_NONE     = 3'd0;
   localparam logic [2:0] CAUSE_USER     = 3'd1;
   localparam logic [2:0] CAUSE_TIMEOUT  = 3'd2;
   localparam logic [2:0] CAUSE_DISABLED = 3'd3;
   localparam logic [2:0] CAUSE_REPEAT   = 3'd4;

   typedef struct packed {
      logic [31:0]     shorts;
      logic [31:0]     timeout;
      logic [ID_W-1:0] timeout_next;
      logic [ID_W-1:0] disabled_next;
      logic [ID_W-1:0] repeat_next;
      logic [15:0]     limit;
      logic [7:0]      start_task;
      logic [7:0]      end_task;
      logic [7:0]      expiry_task;
   } entry_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic read_cur;
      logic load;
      logic eval;
      logic read_next;
      logic enter;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_load;
      logic go_enter;
   } sts_type;

endpackage

>>> design/trs_ctrl.sv
// Controller state machine of the radio sequencer.
module trs_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   input  trs_pkg::sts_type sts,
   output trs_pkg::cmd_type cmd
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_RDCUR = 3'd1;
   localparam logic [2:0] S_EVAL  = 3'd2;
   localparam logic [2:0] S_RDNXT = 3'd3;
   localparam logic [2:0] S_ENTER = 3'd4;
   localparam logic [2:0] S_RESP  = 3'd5;

   logic [2:0] state_ff, state_in;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);

   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_RDCUR;
            end
         end
         S_RDCUR: begin
            if (sts.is_load) begin
               cmd.load = 1'b1;
               state_in = S_RESP;
            end else begin
               cmd.read_cur = 1'b1;
               state_in     = S_EVAL;
            end
         end
         S_EVAL: begin
            cmd.eval = 1'b1;
            state_in = sts.go_enter ? S_RDNXT : S_RESP;
         end
         S_RDNXT: begin
            cmd.read_next = 1'b1;
            state_in      = S_ENTER;
         end
         S_ENTER: begin
            cmd.enter = 1'b1;
            state_in  = S_RESP;
         end
         S_RESP: begin
            if (!rsp_stall) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> design/trs_dpath.sv
// Datapath of the radio sequencer: state table, repeat counters, timer and results.
module trs_dpath #(
   parameter int MAX_ENTRIES = trs_pkg::MAX_ENTRIES_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  trs_pkg::cmd_type          cmd,
   output trs_pkg::sts_type          sts,
   input  logic [1:0]                req_opcode,
   input  logic [trs_pkg::ID_W-1:0]  req_state_id,
   input  logic [31:0]               req_radio_shorts,
   input  logic [31:0]               req_timeout_us,
   input  logic [trs_pkg::ID_W-1:0]  req_timeout_next,
   input  logic [trs_pkg::ID_W-1:0]  req_disabled_next,
   input  logic [15:0]               req_repeat_limit,
   input  logic [trs_pkg::ID_W-1:0]  req_repeat_next,
   input  logic [7:0]                req_start_task,
   input  logic [7:0]                req_end_task,
   input  logic [7:0]                req_expiry_task,
   output logic [1:0]                rsp_status,
   output logic [trs_pkg::ID_W-1:0]  rsp_active_state,
   output logic                      rsp_changed,
   output logic [trs_pkg::ID_W-1:0]  rsp_ended_state,
   output logic [2:0]                rsp_end_cause,
   output logic [31:0]               rsp_shorts_out,
   output logic [7:0]                rsp_fired_start,
   output logic [7:0]                rsp_fired_end,
   output logic [7:0]                rsp_fired_expiry
);

   localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam int IW = trs_pkg::ID_W;

   trs_pkg::entry_type entry_mem [MAX_ENTRIES];
   logic [15:0]        count_mem [MAX_ENTRIES];

   trs_pkg::entry_type ent_q;
   logic [15:0]        cnt_q;

   // Captured request.
   logic [1:0]         op_ff;
   logic [IW-1:0]      id_ff;
   trs_pkg::entry_type new_ff;

   logic [CW-1:0]      table_count_ff, table_count_in;
   logic [IW-1:0]      current_ff, current_in;
   logic [IW-1:0]      pending_ff, pending_in;
   logic [IW-1:0]      next_ff, next_in;
   logic [31:0]        timer_ff, timer_in;
   logic               armed_ff, armed_in;
   logic [31:0]        applied_ff, applied_in;

   logic [1:0]         status_ff, status_in;
   logic               changed_ff, changed_in;
   logic [IW-1:0]      ended_ff, ended_in;
   logic [2:0]         cause_ff, cause_in;
   logic [7:0]         fstart_ff, fstart_in;
   logic [7:0]         fend_ff, fend_in;
   logic [7:0]         fexp_ff, fexp_in;

   logic               cnt_we;
   logic [AW-1:0]      cnt_waddr;
   logic [15:0]        cnt_wdata;
   logic [AW-1:0]      rd_addr;
   logic               table_room;

   logic               trans;
   logic [IW-1:0]      nx;
   logic [2:0]         cs;
   logic [31:0]        tl;

   function automatic logic id_ok(input logic [IW-1:0] id, input logic [CW-1:0] cnt);
      id_ok = (id != '0) && (32'(id) < 32'(cnt)) && (32'(id) < 32'(MAX_ENTRIES));
   endfunction

   assign table_room = (32'(table_count_ff) < 32'(MAX_ENTRIES));
   assign rd_addr    = cmd.read_next ? AW'(next_ff) : AW'(current_ff);

   assign sts.is_load  = (op_ff == trs_pkg::OP_LOAD);
   assign sts.go_enter = trans && (nx != '0);

   assign rsp_status       = status_ff;
   assign rsp_active_state = current_ff;
   assign rsp_changed      = changed_ff;
   assign rsp_ended_state  = ended_ff;
   assign rsp_end_cause    = cause_ff;
   assign rsp_shorts_out   = applied_ff;
   assign rsp_fired_start  = fstart_ff;
   assign rsp_fired_end    = fend_ff;
   assign rsp_fired_expiry = fexp_ff;

   // Result clearing, table load, event evaluation, end of current state and state entry.
   always_comb begin
      trans = 1'b0;
      nx    = '0;
      cs    = trs_pkg::CAUSE_NONE;
      tl    = timer_ff - 32'd1;

      table_count_in = table_count_ff;
      current_in     = current_ff;
      pending_in     = pending_ff;
      next_in        = next_ff;
      timer_in       = timer_ff;
      armed_in       = armed_ff;
      applied_in     = applied_ff;
      status_in      = status_ff;
      changed_in     = changed_ff;
      ended_in       = ended_ff;
      cause_in       = cause_ff;
      fstart_in      = fstart_ff;
      fend_in        = fend_ff;
      fexp_in        = fexp_ff;
      cnt_we         = 1'b0;
      cnt_waddr      = AW'(current_ff);
      cnt_wdata      = '0;

      if (cmd.capture) begin
         status_in  = trs_pkg::ST_OK;
         changed_in = 1'b0;
         ended_in   = '0;
         cause_in   = trs_pkg::CAUSE_NONE;
         fstart_in  = '0;
         fend_in    = '0;
         fexp_in    = '0;
      end

      if (cmd.load) begin
         if (table_room) begin
            table_count_in = table_count_ff + CW'(1);
            cnt_we         = 1'b1;
            cnt_waddr      = AW'(table_count_ff);
         end else begin
            status_in = trs_pkg::ST_FULL;
         end
      end

      if (cmd.eval) begin
         case (op_ff)
            trs_pkg::OP_ACTIVATE: begin
               trans = 1'b1;
               cs    = trs_pkg::CAUSE_USER;
               if (id_ok(id_ff, table_count_ff)) begin
                  nx = id_ff;
               end else begin
                  status_in = trs_pkg::ST_BAD_ID;
               end
            end
            trs_pkg::OP_TICK: begin
               if (armed_ff) begin
                  timer_in = tl;
                  if (tl == '0) begin
                     armed_in = 1'b0;
                     if (current_ff != '0) begin
                        fexp_in = ent_q.expiry_task;
                     end
                     if (pending_ff != '0) begin
                        trans = 1'b1;
                        cs    = trs_pkg::CAUSE_TIMEOUT;
                        nx    = pending_ff;
                     end
                  end
               end
            end
            trs_pkg::OP_DISABLED: begin
               if (current_ff != '0 && ent_q.disabled_next != '0) begin
                  trans = 1'b1;
                  cs    = trs_pkg::CAUSE_DISABLED;
                  if (id_ok(ent_q.disabled_next, table_count_ff)) begin
                     nx = ent_q.disabled_next;
                  end else begin
                     status_in = trs_pkg::ST_BAD_ID;
                  end
               end
            end
            default: begin
               trans = 1'b0;
            end
         endcase

         if (trans && current_ff != '0) begin
            // A state that has reached its repeat limit hands over to its repeat successor.
            if (ent_q.limit != '0 && cnt_q >= ent_q.limit && ent_q.repeat_next != '0) begin
               cnt_we = 1'b1;
               cs     = trs_pkg::CAUSE_REPEAT;
               if (id_ok(ent_q.repeat_next, table_count_ff)) begin
                  nx = ent_q.repeat_next;
               end else begin
                  nx        = '0;
                  status_in = trs_pkg::ST_BAD_ID;
               end
            end
            ended_in = current_ff;
            cause_in = cs;
            fend_in  = ent_q.end_task;
         end
         next_in = nx;
      end

      if (cmd.enter) begin
         if (ent_q.timeout != '0) begin
            timer_in = ent_q.timeout;
            armed_in = 1'b1;
            if (ent_q.timeout_next == '0) begin
               pending_in = '0;
            end else if (id_ok(ent_q.timeout_next, table_count_ff)) begin
               pending_in = ent_q.timeout_next;
            end else begin
               pending_in = '0;
               status_in  = trs_pkg::ST_BAD_ID;
            end
         end
         applied_in = ent_q.shorts;
         fstart_in  = ent_q.start_task;
         cnt_we     = 1'b1;
         cnt_waddr  = AW'(next_ff);
         cnt_wdata  = (cnt_q == 16'hFFFF) ? cnt_q : cnt_q + 16'd1;
         current_in = next_ff;
         changed_in = 1'b1;
      end
   end

   // Table memories with registered read data.
   always_ff @(posedge clock) begin
      if (cmd.load && table_room) begin
         entry_mem[AW'(table_count_ff)] <= new_ff;
      end
      if (cnt_we) begin
         count_mem[cnt_waddr] <= cnt_wdata;
      end
      if (cmd.read_cur || cmd.read_next) begin
         ent_q <= entry_mem[rd_addr];
         cnt_q <= count_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff                <= req_opcode;
         id_ff                <= req_state_id;
         new_ff.shorts        <= req_radio_shorts;
         new_ff.timeout       <= req_timeout_us;
         new_ff.timeout_next  <= req_timeout_next;
         new_ff.disabled_next <= req_disabled_next;
         new_ff.repeat_next   <= req_repeat_next;
         new_ff.limit         <= req_repeat_limit;
         new_ff.start_task    <= req_start_task;
         new_ff.end_task      <= req_end_task;
         new_ff.expiry_task   <= req_expiry_task;
      end
      next_ff    <= next_in;
      status_ff  <= status_in;
      changed_ff <= changed_in;
      ended_ff   <= ended_in;
      cause_ff   <= cause_in;
      fstart_ff  <= fstart_in;
      fend_ff    <= fend_in;
      fexp_ff    <= fexp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         table_count_ff <= CW'(1);
         current_ff     <= '0;
         pending_ff     <= '0;
         timer_ff       <= '0;
         armed_ff       <= 1'b0;
         applied_ff     <= '0;
      end else begin
         table_count_ff <= table_count_in;
         current_ff     <= current_in;
         pending_ff     <= pending_in;
         timer_ff       <= timer_in;
         armed_ff       <= armed_in;
         applied_ff     <= applied_in;
      end
   end

endmodule

>>> design/table_driven_radio_sequencer_unit.sv
// Top level of the table-driven radio sequencer.
//
// Requests arrive on the req_ channel (valid and stall); each one is a load of a
// table entry, an activate, a one-microsecond tick or a radio-disabled event.
// Exactly one response leaves on the rsp_ channel for every request transfer.
// The block works on one request at a time: req_stall is high from the transfer
// until its response has been taken. A load steps through the states S_RDCUR
// and S_RESP; an event that enters no state through S_RDCUR, S_EVAL and S_RESP;
// one that enters a state through S_RDCUR, S_EVAL, S_RDNXT, S_ENTER and S_RESP.
// The next request is taken once the block is back in S_IDLE after the response
// transfer. The single read port of the state table, read first for the current
// state and then for the successor, sets these steps.
// While the receiver holds rsp_stall high the response stays on the rsp_ ports
// unchanged and no new request is taken.
// Reset (synchronous, active high) empties the table, clears the current state,
// the timer and the applied shorts word. Table entries are not cleared; an
// entry is only used once it has been loaded, and loading clears its counter.
module table_driven_radio_sequencer_unit #(
   parameter int MAX_ENTRIES = trs_pkg::MAX_ENTRIES_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [1:0]                req_opcode,
   input  logic [trs_pkg::ID_W-1:0]  req_state_id,
   input  logic [31:0]               req_radio_shorts,
   input  logic [31:0]               req_timeout_us,
   input  logic [trs_pkg::ID_W-1:0]  req_timeout_next,
   input  logic [trs_pkg::ID_W-1:0]  req_disabled_next,
   input  logic [15:0]               req_repeat_limit,
   input  logic [trs_pkg::ID_W-1:0]  req_repeat_next,
   input  logic [7:0]                req_start_task,
   input  logic [7:0]                req_end_task,
   input  logic [7:0]                req_expiry_task,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [1:0]                rsp_status,
   output logic [trs_pkg::ID_W-1:0]  rsp_active_state,
   output logic                      rsp_changed,
   output logic [trs_pkg::ID_W-1:0]  rsp_ended_state,
   output logic [2:0]                rsp_end_cause,
   output logic [31:0]               rsp_shorts_out,
   output logic [7:0]                rsp_fired_start,
   output logic [7:0]                rsp_fired_end,
   output logic [7:0]                rsp_fired_expiry
);

   trs_pkg::cmd_type cmd;
   trs_pkg::sts_type sts;

   trs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   trs_dpath #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_opcode        (req_opcode),
      .req_state_id      (req_state_id),
      .req_radio_shorts  (req_radio_shorts),
      .req_timeout_us    (req_timeout_us),
      .req_timeout_next  (req_timeout_next),
      .req_disabled_next (req_disabled_next),
      .req_repeat_limit  (req_repeat_limit),
      .req_repeat_next   (req_repeat_next),
      .req_start_task    (req_start_task),
      .req_end_task      (req_end_task),
      .req_expiry_task   (req_expiry_task),
      .rsp_status        (rsp_status),
      .rsp_active_state  (rsp_active_state),
      .rsp_changed       (rsp_changed),
      .rsp_ended_state   (rsp_ended_state),
      .rsp_end_cause     (rsp_end_cause),
      .rsp_shorts_out    (rsp_shorts_out),
      .rsp_fired_start   (rsp_fired_start),
      .rsp_fired_end     (rsp_fired_end),
      .rsp_fired_expiry  (rsp_fired_expiry)
   );

endmodule
